### rtl/core/wraparound_tile_scroll_tracker_defines.svh
// ----------------------------------------------------------------------------
// Wrap-around tile scroll tracker: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef WRAPAROUND_TILE_SCROLL_TRACKER_DEFINES_SVH
`define WRAPAROUND_TILE_SCROLL_TRACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define WTST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wtst check failed");

// Consequent checked in the cycle after the antecedent.
`define WTST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wtst check failed");

`endif

### rtl/core/wtst_pkg.sv
// ----------------------------------------------------------------------------
// Wrap-around tile scroll tracker package
// Grid geometry, derived widths, command codes and the run descriptor type.
// ----------------------------------------------------------------------------
package wtst_pkg;

  localparam int TILE_SIZE    = 256;
  localparam int TILES_ACROSS = 8;
  localparam int TILES_DOWN   = 8;

  localparam int COL_W     = $clog2(TILES_ACROSS);
  localparam int ROW_W     = $clog2(TILES_DOWN);
  localparam int OUT_IDX_W = 3;
  localparam int COORD_W   = 32;
  localparam int DELTA_W   = 9;
  // residue plus one clamped delta stays below TILE_SIZE + 256 in magnitude
  localparam int RES_W     = $clog2(TILE_SIZE + 256) + 1;

  localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(TILES_ACROSS - 1);
  localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(TILES_DOWN - 1);
  localparam logic [COORD_W-1:0] TILE_STEP = COORD_W'(TILE_SIZE);
  localparam logic [COORD_W-1:0] HALF_X    = COORD_W'((TILES_ACROSS / 2) * TILE_SIZE);
  localparam logic [COORD_W-1:0] HALF_Y    = COORD_W'((TILES_DOWN / 2) * TILE_SIZE);

  localparam logic CMD_SCROLL   = 1'b0;
  localparam logic CMD_RECENTER = 1'b1;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  typedef enum logic [1:0] {
    KIND_ALL,
    KIND_COL,
    KIND_ROW
  } job_kind_e;

  // One run of dirty tiles, with the state snapshot its corners come from.
  typedef struct packed {
    job_kind_e          kind;
    logic [COL_W-1:0]   line_col;
    logic [ROW_W-1:0]   line_row;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COL_W-1:0]   first_col;
    logic [ROW_W-1:0]   first_row;
    logic               last;
  } job_t;

endpackage

### rtl/core/wtst_job_fifo.sv
// ----------------------------------------------------------------------------
// Run descriptor queue
// Short queue between the command front end and the tile sequencer.
// ----------------------------------------------------------------------------
module wtst_job_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wtst_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output wtst_pkg::job_t  job_o,
  output logic            valid_o
);

  wtst_pkg::job_t                    mem_q [wtst_pkg::JOBQ_DEPTH];
  logic [wtst_pkg::JOBQ_AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [wtst_pkg::JOBQ_AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [wtst_pkg::JOBQ_AW:0]        count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == (wtst_pkg::JOBQ_AW + 1)'(wtst_pkg::JOBQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == wtst_pkg::JOBQ_AW'(wtst_pkg::JOBQ_DEPTH - 1)) ? '0
                                                                            : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == wtst_pkg::JOBQ_AW'(wtst_pkg::JOBQ_DEPTH - 1)) ? '0
                                                                            : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### rtl/core/wtst_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands, updates origin, grid rotation and residues, and turns
// each command into up to two run descriptors for the tile sequencer.
// ----------------------------------------------------------------------------
module wtst_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic                                command_i,
  input  logic signed [wtst_pkg::DELTA_W-1:0] delta_x_i,
  input  logic signed [wtst_pkg::DELTA_W-1:0] delta_y_i,
  input  logic signed [wtst_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [wtst_pkg::COORD_W-1:0] center_y_i,
  output logic                                job_push_o,
  output wtst_pkg::job_t                      job_o,
  input  logic                                job_full_i
);

  localparam int RW = wtst_pkg::RES_W;
  localparam int CW = wtst_pkg::COL_W;
  localparam int WW = wtst_pkg::ROW_W;
  localparam logic signed [RW-1:0] RES_MAX  = RW'(wtst_pkg::TILE_SIZE - 1);
  localparam logic signed [RW-1:0] RES_TILE = RW'(wtst_pkg::TILE_SIZE);

  logic [wtst_pkg::COORD_W-1:0] origin_x_q, origin_y_q;
  logic [CW-1:0]                first_col_q;
  logic [WW-1:0]                first_row_q;
  logic signed [RW-1:0]         res_x_q, res_y_q;
  logic                         pend_a_q, pend_b_q;
  wtst_pkg::job_t               job_a_q, job_b_q;

  logic signed [RW-1:0]         dx_ext, dy_ext, dx_c, dy_c, sum_x, sum_y;
  logic signed [RW-1:0]         res_x_d, res_y_d;
  logic                         cross_px, cross_nx, cross_py, cross_ny;
  logic [wtst_pkg::COORD_W-1:0] ox_d, oy_d;
  logic [CW-1:0]                fc_d, line_x;
  logic [WW-1:0]                fr_d, line_y;
  logic                         accept;

  assign full_o = pend_a_q || pend_b_q;
  assign accept = push_i && !full_o;

  // Clamp deltas so that at most one tile is crossed per axis.
  always_comb begin
    dx_ext = RW'(delta_x_i);
    dy_ext = RW'(delta_y_i);
    dx_c   = dx_ext;
    dy_c   = dy_ext;
    if (dx_ext > RES_MAX) begin
      dx_c = RES_MAX;
    end else if (dx_ext < -RES_MAX) begin
      dx_c = -RES_MAX;
    end
    if (dy_ext > RES_MAX) begin
      dy_c = RES_MAX;
    end else if (dy_ext < -RES_MAX) begin
      dy_c = -RES_MAX;
    end
    sum_x    = res_x_q + dx_c;
    sum_y    = res_y_q + dy_c;
    cross_px = (sum_x >= RES_TILE);
    cross_nx = (sum_x <= -RES_TILE);
    cross_py = (sum_y >= RES_TILE);
    cross_ny = (sum_y <= -RES_TILE);
  end

  // Rotate the grid on the crossed axes and pick the recycled line.
  always_comb begin
    ox_d    = origin_x_q;
    oy_d    = origin_y_q;
    fc_d    = first_col_q;
    fr_d    = first_row_q;
    res_x_d = sum_x;
    res_y_d = sum_y;
    line_x  = '0;
    line_y  = '0;
    if (cross_px) begin
      fc_d    = (first_col_q == wtst_pkg::COL_LAST) ? '0 : first_col_q + 1'b1;
      ox_d    = origin_x_q - wtst_pkg::TILE_STEP;
      res_x_d = sum_x - RES_TILE;
      line_x  = (fc_d == '0) ? '0
              : CW'((CW + 1)'(wtst_pkg::TILES_ACROSS) - (CW + 1)'(fc_d));
    end else if (cross_nx) begin
      fc_d    = (first_col_q == '0) ? wtst_pkg::COL_LAST : first_col_q - 1'b1;
      ox_d    = origin_x_q + wtst_pkg::TILE_STEP;
      res_x_d = sum_x + RES_TILE;
      line_x  = wtst_pkg::COL_LAST - fc_d;
    end
    if (cross_py) begin
      fr_d    = (first_row_q == wtst_pkg::ROW_LAST) ? '0 : first_row_q + 1'b1;
      oy_d    = origin_y_q - wtst_pkg::TILE_STEP;
      res_y_d = sum_y - RES_TILE;
      line_y  = (fr_d == '0) ? '0
              : WW'((WW + 1)'(wtst_pkg::TILES_DOWN) - (WW + 1)'(fr_d));
    end else if (cross_ny) begin
      fr_d    = (first_row_q == '0) ? wtst_pkg::ROW_LAST : first_row_q - 1'b1;
      oy_d    = origin_y_q + wtst_pkg::TILE_STEP;
      res_y_d = sum_y + RES_TILE;
      line_y  = wtst_pkg::ROW_LAST - fr_d;
    end
  end

  // Hand the pending runs to the queue, the column run first.
  assign job_push_o = (pend_a_q || pend_b_q) && !job_full_i;
  assign job_o      = pend_a_q ? job_a_q : job_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      first_col_q <= '0;
      first_row_q <= '0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      pend_a_q    <= 1'b0;
      pend_b_q    <= 1'b0;
    end else if (accept) begin
      if (command_i == wtst_pkg::CMD_RECENTER) begin
        origin_x_q  <= center_x_i - wtst_pkg::HALF_X;
        origin_y_q  <= center_y_i - wtst_pkg::HALF_Y;
        first_col_q <= '0;
        first_row_q <= '0;
        res_x_q     <= '0;
        res_y_q     <= '0;
        pend_a_q    <= 1'b1;
        pend_b_q    <= 1'b0;
      end else begin
        origin_x_q  <= ox_d;
        origin_y_q  <= oy_d;
        first_col_q <= fc_d;
        first_row_q <= fr_d;
        res_x_q     <= res_x_d;
        res_y_q     <= res_y_d;
        pend_a_q    <= cross_px || cross_nx;
        pend_b_q    <= cross_py || cross_ny;
      end
    end else if (job_push_o) begin
      if (pend_a_q) begin
        pend_a_q <= 1'b0;
      end else begin
        pend_b_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (command_i == wtst_pkg::CMD_RECENTER) begin
        job_a_q.kind      <= wtst_pkg::KIND_ALL;
        job_a_q.line_col  <= '0;
        job_a_q.line_row  <= '0;
        job_a_q.origin_x  <= center_x_i - wtst_pkg::HALF_X;
        job_a_q.origin_y  <= center_y_i - wtst_pkg::HALF_Y;
        job_a_q.first_col <= '0;
        job_a_q.first_row <= '0;
        job_a_q.last      <= 1'b1;
      end else begin
        // column corners are taken before the y update
        job_a_q.kind      <= wtst_pkg::KIND_COL;
        job_a_q.line_col  <= line_x;
        job_a_q.line_row  <= '0;
        job_a_q.origin_x  <= ox_d;
        job_a_q.origin_y  <= origin_y_q;
        job_a_q.first_col <= fc_d;
        job_a_q.first_row <= first_row_q;
        job_a_q.last      <= !(cross_py || cross_ny);
      end
      job_b_q.kind      <= wtst_pkg::KIND_ROW;
      job_b_q.line_col  <= '0;
      job_b_q.line_row  <= line_y;
      job_b_q.origin_x  <= ox_d;
      job_b_q.origin_y  <= oy_d;
      job_b_q.first_col <= fc_d;
      job_b_q.first_row <= fr_d;
      job_b_q.last      <= 1'b1;
    end
  end

endmodule

### rtl/core/wtst_back.sv
// ----------------------------------------------------------------------------
// Tile sequencer
// Walks the run at the head of the queue and emits one dirty tile per cycle
// into the result register, while that register is empty or being popped.
// ----------------------------------------------------------------------------
module wtst_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  job_valid_i,
  input  wtst_pkg::job_t                        job_i,
  output logic                                  job_pop_o,
  output logic                                  empty_o,
  input  logic                                  pop_i,
  output logic [wtst_pkg::OUT_IDX_W-1:0]        tile_col_o,
  output logic [wtst_pkg::OUT_IDX_W-1:0]        tile_row_o,
  output logic signed [wtst_pkg::COORD_W-1:0]   tile_left_o,
  output logic signed [wtst_pkg::COORD_W-1:0]   tile_top_o,
  output logic                                  last_of_run_o
);

  localparam int CW = wtst_pkg::COL_W;
  localparam int WW = wtst_pkg::ROW_W;

  logic [CW-1:0]   col_cnt_q, col_cnt_d;
  logic [WW-1:0]   row_cnt_q, row_cnt_d;
  logic            out_valid_q;
  logic            emit, run_end;
  logic [CW-1:0]   col, cx;
  logic [WW-1:0]   row, cy;
  logic [CW:0]     sum_c;
  logic [WW:0]     sum_r;
  logic [wtst_pkg::COORD_W-1:0] left, top;

  assign empty_o   = !out_valid_q;
  assign emit      = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = emit && run_end;

  always_comb begin
    col = (job_i.kind == wtst_pkg::KIND_COL) ? job_i.line_col : col_cnt_q;
    row = (job_i.kind == wtst_pkg::KIND_ROW) ? job_i.line_row : row_cnt_q;
    // canvas line held by this array position, modulo the grid size
    sum_c = (CW + 1)'(col) + (CW + 1)'(job_i.first_col);
    sum_r = (WW + 1)'(row) + (WW + 1)'(job_i.first_row);
    cx = (sum_c >= (CW + 1)'(wtst_pkg::TILES_ACROSS))
       ? CW'(sum_c - (CW + 1)'(wtst_pkg::TILES_ACROSS)) : CW'(sum_c);
    cy = (sum_r >= (WW + 1)'(wtst_pkg::TILES_DOWN))
       ? WW'(sum_r - (WW + 1)'(wtst_pkg::TILES_DOWN)) : WW'(sum_r);
    left = job_i.origin_x + wtst_pkg::COORD_W'(cx) * wtst_pkg::TILE_STEP;
    top  = job_i.origin_y + wtst_pkg::COORD_W'(cy) * wtst_pkg::TILE_STEP;
  end

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    run_end   = 1'b0;
    unique case (job_i.kind)
      wtst_pkg::KIND_ALL: begin
        run_end = (col_cnt_q == wtst_pkg::COL_LAST) && (row_cnt_q == wtst_pkg::ROW_LAST);
        if (row_cnt_q == wtst_pkg::ROW_LAST) begin
          row_cnt_d = '0;
          col_cnt_d = col_cnt_q + 1'b1;
        end else begin
          row_cnt_d = row_cnt_q + 1'b1;
        end
      end
      wtst_pkg::KIND_COL: begin
        run_end   = (row_cnt_q == wtst_pkg::ROW_LAST);
        row_cnt_d = row_cnt_q + 1'b1;
      end
      wtst_pkg::KIND_ROW: begin
        run_end   = (col_cnt_q == wtst_pkg::COL_LAST);
        col_cnt_d = col_cnt_q + 1'b1;
      end
      default: begin
        run_end = 1'b1;
      end
    endcase
    if (run_end) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      tile_col_o    <= wtst_pkg::OUT_IDX_W'(col);
      tile_row_o    <= wtst_pkg::OUT_IDX_W'(row);
      tile_left_o   <= left;
      tile_top_o    <= top;
      last_of_run_o <= run_end && job_i.last;
    end
  end

endmodule

### rtl/core/wraparound_tile_scroll_tracker.sv
// ----------------------------------------------------------------------------
// Wrap-around tile scroll tracker
// Tracks a toroidal grid of tiles over a scrolling canvas and reports the
// tiles that must be redrawn after each recenter or scroll command.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port (push/full) and dirty tiles leave
// through another (empty/pop), oldest first. A recenter places the covered
// area around center_x/center_y, resets the grid rotation and residues, and
// reports every tile, column by column, rows inner. A scroll clamps each
// delta to less than one tile, adds it to the sub-tile residue, and for each
// axis on which a whole tile is crossed rotates the grid by one, moves the
// origin by one tile, and reports the recycled column (x first) and then the
// recycled row. A scroll that crosses nothing reports nothing. The final tile
// of each command has last_of_run set. The front end registers a command
// and then hands its runs (one or two), one at a time, to a two-entry run
// queue; full is high during that handoff. The tile sequencer then emits
// one tile per cycle while the result register is free or being popped, so
// a recenter reports TILES_ACROSS*TILES_DOWN tiles (64 at the default
// geometry) and a scroll up to TILES_ACROSS+TILES_DOWN tiles (16); this
// walk sets the sustained rate. A stalled pop holds the result
// register, which in turn holds the sequencer while the front end keeps
// taking commands until the run queue fills.
// ----------------------------------------------------------------------------
module wraparound_tile_scroll_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                command_i,
  input  logic signed [wtst_pkg::DELTA_W-1:0] delta_x_i,
  input  logic signed [wtst_pkg::DELTA_W-1:0] delta_y_i,
  input  logic signed [wtst_pkg::COORD_W-1:0] center_x_i,
  input  logic signed [wtst_pkg::COORD_W-1:0] center_y_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [wtst_pkg::OUT_IDX_W-1:0]      tile_col_o,
  output logic [wtst_pkg::OUT_IDX_W-1:0]      tile_row_o,
  output logic signed [wtst_pkg::COORD_W-1:0] tile_left_o,
  output logic signed [wtst_pkg::COORD_W-1:0] tile_top_o,
  output logic                                last_of_run_o
);

  // run descriptors from the front end into the queue
  logic           fe_push;
  wtst_pkg::job_t fe_job;
  logic           q_full;

  // head of the queue into the sequencer
  wtst_pkg::job_t q_job;
  logic           q_valid;
  logic           be_pop;

  // Classify commands, update the tracking state, build runs.
  wtst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .command_i  (command_i),
    .delta_x_i  (delta_x_i),
    .delta_y_i  (delta_y_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .job_push_o (fe_push),
    .job_o      (fe_job),
    .job_full_i (q_full)
  );

  // Decouple command intake from tile emission.
  wtst_job_fifo u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .job_i   (fe_job),
    .full_o  (q_full),
    .pop_i   (be_pop),
    .job_o   (q_job),
    .valid_o (q_valid)
  );

  // Walk each run and drive the result register.
  wtst_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (q_job),
    .job_pop_o     (be_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .tile_col_o    (tile_col_o),
    .tile_row_o    (tile_row_o),
    .tile_left_o   (tile_left_o),
    .tile_top_o    (tile_top_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### rtl/core/wtst_checker.sv
// ----------------------------------------------------------------------------
// Wrap-around tile scroll tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "wraparound_tile_scroll_tracker_defines.svh"

module wtst_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                push,
  input logic                                full,
  input logic                                command_i,
  input logic                                empty,
  input logic                                pop,
  input logic [wtst_pkg::OUT_IDX_W-1:0]      tile_col_o,
  input logic [wtst_pkg::OUT_IDX_W-1:0]      tile_row_o,
  input logic signed [wtst_pkg::COORD_W-1:0] tile_left_o,
  input logic signed [wtst_pkg::COORD_W-1:0] tile_top_o,
  input logic                                last_of_run_o
);

  // hold a waiting result until it is taken
  `WTST_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(last_of_run_o))

  // hold the tile corners of a waiting result
  `WTST_ASSERT_NEXT(a_payload_hold, !empty && !pop, $stable(tile_left_o) && $stable(tile_top_o))

  // hold the array position of a waiting result
  `WTST_ASSERT_NEXT(a_index_hold, !empty && !pop, $stable(tile_col_o) && $stable(tile_row_o))

  // a taken recenter always leaves a run to hand off
  `WTST_ASSERT_NEXT(a_recenter_busy, push && !full && (command_i == wtst_pkg::CMD_RECENTER), full)

endmodule

bind wraparound_tile_scroll_tracker wtst_checker u_wtst_checker (.*);
